// ===== rtl/rgbab_pkg.sv =====
// Package: shared constants, types and helpers of the RGB565 alpha blend and clip writer.
`timescale 1ns / 1ps

package rgbab_pkg;

  // Width of the bitmap row and column coordinates.
  localparam int COORD_BITS = 12;

  // Signed width that holds a bitmap coordinate plus a 16-bit signed offset.
  // It also holds a clip edge plus a clip extent without wrapping.
  localparam int SUM_W = 18;

  // Field widths of one request.
  localparam int PIX_W   = 16;
  localparam int ALPHA_W = 5;
  localparam int CFG_W   = 16;
  localparam int EXT_W   = 15;
  localparam int IDX_W   = 3;

  // Bit positions of the request fields inside in_tdata.
  localparam int ROW_LSB   = 0;
  localparam int COL_LSB   = ROW_LSB + COORD_BITS;
  localparam int FG_LSB    = COL_LSB + COORD_BITS;
  localparam int ALPHA_LSB = FG_LSB + PIX_W;
  localparam int BG_LSB    = ALPHA_LSB + ALPHA_W;
  localparam int IN_BITS   = BG_LSB + PIX_W;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;

  // Result layout: write enable in bit zero, window word above it.
  localparam int OUT_BITS = 1 + PIX_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Transparency code that keeps the background untouched.
  localparam logic [ALPHA_W-1:0] ALPHA_KEEP_BG = 5'h1F;

  // Configuration register indices.
  typedef enum logic [IDX_W-1:0] {
    REG_POS_X       = 3'd0,
    REG_POS_Y       = 3'd1,
    REG_CLIP_LEFT   = 3'd2,
    REG_CLIP_TOP    = 3'd3,
    REG_CLIP_WIDTH  = 3'd4,
    REG_CLIP_HEIGHT = 3'd5,
    REG_SWAP_ORDER  = 3'd6,
    REG_USE_ALPHA   = 3'd7
  } cfg_reg_t;

  // How the stored colour is formed.
  typedef enum logic [1:0] {
    MODE_FG  = 2'd0,
    MODE_BG  = 2'd1,
    MODE_MIX = 2'd2
  } mix_mode_t;

  // Control handed from the top level to the blend datapath.
  typedef struct packed {
    logic load;
    logic swap_order;
    logic use_alpha;
  } blend_ctrl_t;

  function automatic logic [PIX_W-1:0] bswap16(input logic [PIX_W-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

// ===== rtl/rgbab_blend.sv =====
// Blend datapath: byte order, channel products (registered) and the final sums.
`timescale 1ns / 1ps

module rgbab_blend (
  input  logic                                   clk,
  input  rgbab_pkg::blend_ctrl_t                 ctrl,
  input  logic [rgbab_pkg::PIX_W-1:0]            fg_pixel,
  input  logic [rgbab_pkg::ALPHA_W-1:0]          transparency,
  input  logic [rgbab_pkg::PIX_W-1:0]            bg_word,
  output logic [rgbab_pkg::PIX_W-1:0]            win_word
);
  import rgbab_pkg::*;

  // Stage two inputs, derived combinationally.
  logic [PIX_W-1:0] bc;
  logic [5:0]       t;
  logic [5:0]       inv;
  mix_mode_t        mode_nxt;

  // Stage two registers.
  mix_mode_t        mode_r;
  logic [PIX_W-1:0] fc_r;
  logic [PIX_W-1:0] bc_r;
  logic [10:0]      prb_r, prf_r, pbb_r, pbf_r;
  logic [11:0]      pgb_r, pgf_r;

  // Stage three logic.
  logic [10:0]      sum_r;
  logic [11:0]      sum_g;
  logic [10:0]      sum_b;
  logic [PIX_W-1:0] oc;

  always_comb begin
    bc  = ctrl.swap_order ? bg_word : bswap16(bg_word);
    t   = {1'b0, transparency} + 6'd1;
    inv = 6'd32 - t;
    if (!ctrl.use_alpha || transparency == '0) begin
      mode_nxt = MODE_FG;
    end else if (transparency == ALPHA_KEEP_BG) begin
      mode_nxt = MODE_BG;
    end else begin
      mode_nxt = MODE_MIX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mode_r <= mode_nxt;
      fc_r   <= fg_pixel;
      bc_r   <= bc;
      prb_r  <= 11'(bc[15:11]) * 11'(t);
      prf_r  <= 11'(fg_pixel[15:11]) * 11'(inv);
      pgb_r  <= 12'(bc[10:5]) * 12'(t);
      pgf_r  <= 12'(fg_pixel[10:5]) * 12'(inv);
      pbb_r  <= 11'(bc[4:0]) * 11'(t);
      pbf_r  <= 11'(fg_pixel[4:0]) * 11'(inv);
    end
  end

  always_comb begin
    sum_r = prb_r + prf_r;
    sum_g = pgb_r + pgf_r;
    sum_b = pbb_r + pbf_r;
    case (mode_r)
      MODE_FG:  oc = fc_r;
      MODE_BG:  oc = bc_r;
      MODE_MIX: oc = {sum_r[9:5], sum_g[10:5], sum_b[9:5]};
      default:  oc = fc_r;
    endcase
    win_word = ctrl.swap_order ? oc : bswap16(oc);
  end

endmodule

// ===== rtl/rgb565_alpha_blend_clip.sv =====
// Top level: clipped, alpha-blended RGB565 pixel writer with a three-stage pipeline.
`timescale 1ns / 1ps

// Channel  Direction  Payload (lowest bit up)                          Handshake
// in_      slave      row, col, fg_pixel, transparency, bg_word         tvalid/tready
// out_     master     write_enable, out_word                            tvalid/tready
// cfg_     write      cfg_index selects register, cfg_wdata value       cfg_wen, no wait
//
// A request accepted at a clock edge passes three register stages and leaves from the
// third. A new request may be accepted in every cycle unless a stalled output has filled
// the pipeline, so the sustained rate is one pixel per clock while the output is ready.
// Stage one forms the window position, stage two compares it with the clip rectangle
// and registers the channel products, stage three sums, selects and swaps the bytes.
// Every stage has its own valid bit, and a stage moves on whenever the stage after it is
// empty or moving, so a stalled output does not block the input while bubbles remain.
// The synchronous active-low reset empties the pipeline and clears the configuration
// registers to zero; the data registers are not reset, as the valid bits guard them.

module rgb565_alpha_blend_clip (
  input  logic                           clk,
  input  logic                           rst_n,
  // row, col, fg_pixel, transparency, bg_word; zero padded to whole bytes
  input  logic [rgbab_pkg::IN_W-1:0]     in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // write_enable, out_word; zero padded to whole bytes
  output logic [rgbab_pkg::OUT_W-1:0]    out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_wen,
  input  logic [rgbab_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rgbab_pkg::CFG_W-1:0]    cfg_wdata
);
  import rgbab_pkg::*;

  // Configuration registers.
  logic signed [CFG_W-1:0] pos_x_r, pos_y_r, clip_left_r, clip_top_r;
  logic [EXT_W-1:0]        clip_width_r, clip_height_r;
  logic                    swap_order_r, use_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_width_r  <= '0;
      clip_height_r <= '0;
      swap_order_r  <= 1'b0;
      use_alpha_r   <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POS_X:       pos_x_r       <= cfg_wdata;
        REG_POS_Y:       pos_y_r       <= cfg_wdata;
        REG_CLIP_LEFT:   clip_left_r   <= cfg_wdata;
        REG_CLIP_TOP:    clip_top_r    <= cfg_wdata;
        REG_CLIP_WIDTH:  clip_width_r  <= cfg_wdata[EXT_W-1:0];
        REG_CLIP_HEIGHT: clip_height_r <= cfg_wdata[EXT_W-1:0];
        REG_SWAP_ORDER:  swap_order_r  <= cfg_wdata[0];
        REG_USE_ALPHA:   use_alpha_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage may load when it is empty or its contents move on.
  logic v1_r, v2_r, v3_r;
  logic ready1, ready2, ready3;
  logic in_acc, out_acc;

  assign ready3    = !v3_r || out_tready;
  assign ready2    = !v2_r || ready3;
  assign ready1    = !v1_r || ready2;
  assign in_tready = ready1;
  assign in_acc    = in_tvalid && ready1;
  assign out_acc   = v3_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_tvalid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  // Stage one: window position of the pixel.
  logic [COORD_BITS-1:0]    in_row, in_col;
  logic signed [SUM_W-1:0]  wx_nxt, wy_nxt;
  logic signed [SUM_W-1:0]  wx_r, wy_r;
  logic [PIX_W-1:0]         fg1_r, bg1_r;
  logic [ALPHA_W-1:0]       alpha1_r;

  assign in_row = in_tdata[ROW_LSB +: COORD_BITS];
  assign in_col = in_tdata[COL_LSB +: COORD_BITS];
  assign wx_nxt = $signed({{(SUM_W-COORD_BITS){1'b0}}, in_col})
                + $signed({{(SUM_W-CFG_W){pos_x_r[CFG_W-1]}}, pos_x_r});
  assign wy_nxt = $signed({{(SUM_W-COORD_BITS){1'b0}}, in_row})
                + $signed({{(SUM_W-CFG_W){pos_y_r[CFG_W-1]}}, pos_y_r});

  always_ff @(posedge clk) begin
    if (in_acc) begin
      wx_r     <= wx_nxt;
      wy_r     <= wy_nxt;
      fg1_r    <= in_tdata[FG_LSB +: PIX_W];
      alpha1_r <= in_tdata[ALPHA_LSB +: ALPHA_W];
      bg1_r    <= in_tdata[BG_LSB +: PIX_W];
    end
  end

  // Stage two: clip test. The rectangle is half open on its right and bottom edges.
  logic signed [SUM_W-1:0] left_s, top_s, right_s, bottom_s;
  logic                    inside_nxt;
  logic                    inside2_r;
  logic [PIX_W-1:0]        bg2_r;
  logic                    load2;

  assign load2    = ready2 && v1_r;
  assign left_s   = $signed({{(SUM_W-CFG_W){clip_left_r[CFG_W-1]}}, clip_left_r});
  assign top_s    = $signed({{(SUM_W-CFG_W){clip_top_r[CFG_W-1]}}, clip_top_r});
  assign right_s  = left_s + $signed({{(SUM_W-EXT_W){1'b0}}, clip_width_r});
  assign bottom_s = top_s + $signed({{(SUM_W-EXT_W){1'b0}}, clip_height_r});
  assign inside_nxt = (wx_r >= left_s) && (wx_r < right_s)
                   && (wy_r >= top_s) && (wy_r < bottom_s);

  always_ff @(posedge clk) begin
    if (load2) begin
      inside2_r <= inside_nxt;
      bg2_r     <= bg1_r;
    end
  end

  // The blend datapath registers its products alongside stage two.
  blend_ctrl_t      bctrl;
  logic [PIX_W-1:0] win_word;

  assign bctrl.load       = load2;
  assign bctrl.swap_order = swap_order_r;
  assign bctrl.use_alpha  = use_alpha_r;

  rgbab_blend u_blend (
    .clk          (clk),
    .ctrl         (bctrl),
    .fg_pixel     (fg1_r),
    .transparency (alpha1_r),
    .bg_word      (bg1_r),
    .win_word     (win_word)
  );

  // Stage three: the output register. A pixel outside the clip passes the background word unchanged.
  logic             we3_r;
  logic [PIX_W-1:0] word3_r;

  always_ff @(posedge clk) begin
    if (ready3 && v2_r) begin
      we3_r   <= inside2_r;
      word3_r <= inside2_r ? win_word : bg2_r;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, word3_r, we3_r};

  // The number of requests in flight changes only through the two handshakes.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      $countones({v1_r, v2_r, v3_r}) ==
      $past($countones({v1_r, v2_r, v3_r})) + ($past(in_acc) ? 1 : 0)
        - ($past(out_acc) ? 1 : 0))
    else $error("pipeline occupancy does not follow the handshakes");

  // A full middle stage that cannot move keeps its request.
  a_hold_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !ready3) |=> (v2_r && $stable(inside2_r) && $stable(bg2_r)))
    else $error("stalled middle stage lost or changed its request");

  // A clipped pixel leaves the window word unchanged.
  a_clip_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (ready3 && v2_r && !inside2_r) |=> (!we3_r && word3_r == $past(bg2_r)))
    else $error("clipped pixel did not pass the window word");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the clipped, alpha-blended RGB565 pixel writer.
`timescale 1ns / 1ps

module testbench;
  import rgbab_pkg::*;

  // The run is ended by force if it has not finished after this many clock cycles.
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASES = 11;
  localparam int PHASE_REQUESTS = 100;
  localparam int DIR_ROWS = 21;

  // One register setting of the block, held as the raw register contents.
  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] clip_left;
    logic [15:0] clip_top;
    logic [14:0] clip_width;
    logic [14:0] clip_height;
    logic        swap_order;
    logic        use_alpha;
  } cfg_set_t;

  // One pixel request, with the register setting it runs under and, where it is obvious,
  // the window word that must come back.
  typedef struct packed {
    logic [1:0]  set_sel;
    logic [11:0] row;
    logic [11:0] col;
    logic [15:0] fg;
    logic [4:0]  alpha;
    logic [15:0] bg;
    logic        typed;
    logic        exp_we;
    logic [15:0] exp_word;
  } pixel_row_t;

  // What the block should produce for one request, and which colour path it took.
  typedef struct packed {
    mix_mode_t   mode;
    logic        we;
    logic [15:0] word;
  } blend_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [IN_W-1:0]     in_tdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_wen = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  // Register contents as the block should currently hold them.
  cfg_set_t      live_cfg = '0;
  // Window words still owed by the block, oldest first.
  blend_result_t pending_results [$];

  int  errors = 0;
  int  cycles = 0;
  int  stall_left = 0;
  int  n_requests = 0;
  int  n_settings = 0;
  int  n_written = 0;
  int  n_clipped = 0;
  int  n_fg = 0;
  int  n_bg = 0;
  int  n_mix = 0;
  // When set, neither side inserts idle cycles.
  bit  calm = 1'b0;

  cfg_set_t   dir_set [4];
  // Directed requests. Setting 0 is the state after reset, where the clip rectangle is
  // empty and every window word must come back untouched. Setting 1 covers the whole
  // bitmap with transparency on and no byte swap. Setting 2 places a five-pixel strip at
  // the extremes of the signed coordinate range, with transparency off and the window
  // bytes swapped. Setting 3 has a clip rectangle of zero width.
  pixel_row_t dir_tab [DIR_ROWS] = '{
    '{2'd0, 12'd0,    12'd0,    16'hFFFF, 5'd0,  16'h0000, 1'b1, 1'b0, 16'h0000},
    '{2'd0, 12'd4095, 12'd4095, 16'h1234, 5'd31, 16'hBEEF, 1'b1, 1'b0, 16'hBEEF},
    '{2'd0, 12'd100,  12'd200,  16'hA5A5, 5'd7,  16'h5A5A, 1'b1, 1'b0, 16'h5A5A},
    '{2'd1, 12'd0,    12'd0,    16'hFFFF, 5'd0,  16'h0000, 1'b1, 1'b1, 16'hFFFF},
    '{2'd1, 12'd4095, 12'd4095, 16'h1234, 5'd31, 16'hABCD, 1'b1, 1'b1, 16'hABCD},
    '{2'd1, 12'd4095, 12'd0,    16'hFFFF, 5'd1,  16'h0000, 1'b0, 1'b0, 16'h0000},
    '{2'd1, 12'd0,    12'd4095, 16'h0000, 5'd1,  16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{2'd1, 12'd1,    12'd1,    16'hFFFF, 5'd15, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{2'd1, 12'd2,    12'd3,    16'hF800, 5'd30, 16'h07E0, 1'b0, 1'b0, 16'h0000},
    '{2'd1, 12'd2,    12'd3,    16'h001F, 5'd16, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{2'd1, 12'd2048, 12'd2047, 16'hFFFF, 5'd30, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{2'd1, 12'd1365, 12'd2730, 16'h5555, 5'd10, 16'hAAAA, 1'b0, 1'b0, 16'h0000},
    '{2'd2, 12'd0,    12'd9,    16'h1234, 5'd5,  16'hCAFE, 1'b1, 1'b0, 16'hCAFE},
    '{2'd2, 12'd0,    12'd10,   16'h1234, 5'd5,  16'hCAFE, 1'b1, 1'b1, 16'h3412},
    '{2'd2, 12'd0,    12'd14,   16'h00FF, 5'd31, 16'h0000, 1'b1, 1'b1, 16'hFF00},
    '{2'd2, 12'd0,    12'd15,   16'h00FF, 5'd31, 16'h0F0F, 1'b1, 1'b0, 16'h0F0F},
    '{2'd2, 12'd1,    12'd12,   16'h8001, 5'd0,  16'h7777, 1'b1, 1'b0, 16'h7777},
    '{2'd2, 12'd0,    12'd12,   16'h8001, 5'd0,  16'h7777, 1'b1, 1'b1, 16'h0180},
    '{2'd3, 12'd0,    12'd0,    16'hFFFF, 5'd0,  16'h1357, 1'b1, 1'b0, 16'h1357},
    '{2'd3, 12'd4095, 12'd4095, 16'h0000, 5'd12, 16'hFFFF, 1'b1, 1'b0, 16'hFFFF},
    '{2'd3, 12'd10,   12'd20,   16'hC3C3, 5'd31, 16'h2468, 1'b1, 1'b0, 16'h2468}
  };

  rgb565_alpha_blend_clip i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    // row, col, fg_pixel, transparency, bg_word, zero padding
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // write_enable, out_word, zero padding
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Works out the window word for one pixel. The window position is formed in plain
  // integers, so no offset or clip edge can wrap. Channels are blended in the
  // foreground's byte order, and the window word is converted on the way in and out
  // when the first memory byte is the low byte.
  function automatic blend_result_t predict_pixel(cfg_set_t c, logic [11:0] row,
                                                  logic [11:0] col, logic [15:0] fg,
                                                  logic [4:0] alpha, logic [15:0] bg);
    blend_result_t r;
    int            wx;
    int            wy;
    int            left;
    int            top;
    int            t;
    logic [15:0]   bc;
    logic [15:0]   oc;
    wx   = int'(col) + int'($signed(c.pos_x));
    wy   = int'(row) + int'($signed(c.pos_y));
    left = int'($signed(c.clip_left));
    top  = int'($signed(c.clip_top));
    r.mode = MODE_FG;
    r.we   = 1'b0;
    r.word = bg;
    if (wx >= left && wx < left + int'(c.clip_width) &&
        wy >= top && wy < top + int'(c.clip_height)) begin
      bc = c.swap_order ? bg : {bg[7:0], bg[15:8]};
      if (!c.use_alpha || alpha == '0) begin
        oc = fg;
      end else if (alpha == ALPHA_KEEP_BG) begin
        r.mode = MODE_BG;
        oc = bc;
      end else begin
        // Weight of the background is alpha + 1 out of 32.
        r.mode = MODE_MIX;
        t = int'(alpha) + 1;
        oc[4:0]   = 5'((int'(bc[4:0]) * t + int'(fg[4:0]) * (32 - t)) >> 5);
        oc[10:5]  = 6'((int'(bc[10:5]) * t + int'(fg[10:5]) * (32 - t)) >> 5);
        oc[15:11] = 5'((int'(bc[15:11]) * t + int'(fg[15:11]) * (32 - t)) >> 5);
      end
      r.we   = 1'b1;
      r.word = c.swap_order ? oc : {oc[7:0], oc[15:8]};
    end
    return r;
  endfunction

  // Mostly no gap or a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Writes every register. Bits above a register's width carry random values, which the
  // block must ignore.
  task automatic apply_setting(cfg_set_t s);
    write_reg(REG_POS_X, s.pos_x);
    write_reg(REG_POS_Y, s.pos_y);
    write_reg(REG_CLIP_LEFT, s.clip_left);
    write_reg(REG_CLIP_TOP, s.clip_top);
    write_reg(REG_CLIP_WIDTH, {1'($urandom), s.clip_width});
    write_reg(REG_CLIP_HEIGHT, {1'($urandom), s.clip_height});
    write_reg(REG_SWAP_ORDER, {15'($urandom), s.swap_order});
    write_reg(REG_USE_ALPHA, {15'($urandom), s.use_alpha});
    cfg_wen  <= 1'b0;
    live_cfg = s;
    n_settings++;
  endtask

  // Offers one request after a random gap and records its expected result once the
  // block has taken it. The valid stays high afterwards, so back-to-back requests need
  // no extra cycle.
  task automatic send_request(pixel_row_t p);
    blend_result_t res;
    int            gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {3'b000, p.bg, p.alpha, p.fg, p.col, p.row};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    res = predict_pixel(live_cfg, p.row, p.col, p.fg, p.alpha, p.bg);
    if (!res.we) n_clipped++;
    else if (res.mode == MODE_FG) n_fg++;
    else if (res.mode == MODE_BG) n_bg++;
    else n_mix++;
    if (res.we) n_written++;
    if (p.typed) begin
      res.we   = p.exp_we;
      res.word = p.exp_word;
    end
    pending_results.push_back(res);
    n_requests++;
  endtask

  // Stops offering requests and waits until every owed result has come back, so that
  // the registers can be rewritten safely.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: compares every accepted result with the oldest expectation, then
  // decides whether to stall in the next cycle.
  always @(posedge clk) begin
    blend_result_t want;
    int            n;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %h arrived with nothing expected", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.we)
          report_error($sformatf("write_enable %b, expected %b", out_tdata[0], want.we));
        if (out_tdata[16:1] !== want.word)
          report_error($sformatf("out_word %h, expected %h", out_tdata[16:1], want.word));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      n = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
      out_tready <= (n == 0);
      stall_left = (n > 0) ? n - 1 : 0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results owed.",
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    cfg_set_t   s;
    pixel_row_t p;
    logic [1:0] cur_set;
    int         r;

    dir_set[0] = '0;
    dir_set[1] = '{16'd0, 16'd0, 16'd0, 16'd0, 15'd4096, 15'd4096, 1'b1, 1'b1};
    dir_set[2] = '{16'h8000, 16'h7FFF, 16'h800A, 16'h7FFF, 15'd5, 15'd1, 1'b0, 1'b0};
    dir_set[3] = '{16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 15'd4096, 1'b1, 1'b1};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The registers are rewritten whenever the table moves on to another
    // setting, and only once the block has emptied.
    cur_set = 2'd0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].set_sel != cur_set) begin
        drain();
        cur_set = dir_tab[i].set_sel;
        apply_setting(dir_set[cur_set]);
      end
      send_request(dir_tab[i]);
    end

    // Random part. The first phases put the offsets and the clip rectangle at the ends of
    // their ranges, one has a clip rectangle of zero height, and the rest place a small
    // rectangle near the bitmap's origin so that pixels fall on both sides of each edge.
    for (int k = 0; k < PHASES; k++) begin
      drain();
      s.pos_x       = 16'($urandom_range(0, 400)) - 16'd200;
      s.pos_y       = 16'($urandom_range(0, 400)) - 16'd200;
      s.clip_left   = 16'($urandom_range(0, 400)) - 16'd200;
      s.clip_top    = 16'($urandom_range(0, 400)) - 16'd200;
      s.clip_width  = 15'($urandom_range(0, 600));
      s.clip_height = 15'($urandom_range(0, 600));
      s.swap_order  = 1'($urandom);
      s.use_alpha   = ($urandom_range(0, 3) != 0);
      if (k == 0) begin
        s.pos_x = 16'h7FFF; s.pos_y = 16'h7FFF;
        s.clip_left = 16'h7FFF; s.clip_top = 16'h7FFF;
        s.clip_width = 15'h7FFF; s.clip_height = 15'h7FFF;
        s.use_alpha = 1'b1;
      end else if (k == 1) begin
        s.pos_x = 16'h8000; s.pos_y = 16'h8000;
        s.clip_left = 16'h8000; s.clip_top = 16'h8000;
        s.clip_width = 15'h7FFF; s.clip_height = 15'h7FFF;
        s.use_alpha = 1'b1;
      end else if (k == 2) begin
        s.clip_height = 15'd0;
      end
      apply_setting(s);
      calm = (k % 4 == 3);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        p = '0;
        p.row = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 511));
        p.col = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 511));
        p.fg  = 16'($urandom);
        p.bg  = 16'($urandom);
        r = $urandom_range(0, 7);
        p.alpha = (r == 0) ? 5'd0 : (r == 1) ? ALPHA_KEEP_BG : 5'($urandom);
        send_request(p);
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Ran %0d pixel requests under %0d register settings; %0d written, %0d clipped.",
             n_requests, n_settings, n_written, n_clipped);
    $display("Written pixels: %0d foreground, %0d background kept, %0d blended.",
             n_fg, n_bg, n_mix);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
